// ===== rtl/cle_pkg.sv =====
// Shared types, constants and helper functions for the cursor line editor.
// Used by cle_core and cursor_line_editor; depends on nothing else.
package cle_pkg;

    localparam int BUF_CAP_DEF = 32;

    localparam int FUNC_W = 3;
    localparam int KEY_W  = 16;
    localparam int POS_W  = 5;
    localparam int CHAR_W = 8;
    localparam int CNT_W  = 16;
    localparam int STAT_W = 3;

    localparam logic [FUNC_W-1:0] FN_KEY    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SETCUR = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

    localparam logic [CHAR_W-1:0] KEY_BS   = 8'h08;
    localparam logic [CHAR_W-1:0] KEY_LF   = 8'h0a;
    localparam logic [CHAR_W-1:0] KEY_CR   = 8'h0d;
    localparam logic [CHAR_W-1:0] KEY_ESC  = 8'h1b;
    localparam logic [CHAR_W-1:0] KEY_DEL  = 8'h7f;
    localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7e;

    localparam logic [STAT_W-1:0] ST_INS  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DEL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_REJ  = 3'd2;
    localparam logic [STAT_W-1:0] ST_ACC  = 3'd3;
    localparam logic [STAT_W-1:0] ST_CAN  = 3'd4;
    localparam logic [STAT_W-1:0] ST_IGN  = 3'd5;
    localparam logic [STAT_W-1:0] ST_DONE = 3'd6;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [POS_W-1:0] MAX_LENGTH_RST = 5'd31;

    // Register select bit of paddr: register 0 holds max_length.
    localparam logic REG_MAX_LENGTH = 1'b0;

    typedef enum logic [3:0] {
        OP_IGN,
        OP_ACC,
        OP_CAN,
        OP_REJ,
        OP_BKSP,
        OP_DELETE,
        OP_INS,
        OP_CLEAR,
        OP_APPEND,
        OP_SETCUR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_FIN
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/cle_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cle_core.sv =====
// Sequencer and datapath of the line editor: key decode, line state, counters
// and the shared index stepper that moves entries of the character RAM.
// Depends on cle_pkg.
module cle_core
    import cle_pkg::*;
#(
    parameter int BUF_CAP = BUF_CAP_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FUNC_W-1:0] func,
    input  logic [KEY_W-1:0]  key_code,
    input  logic [POS_W-1:0]  position,
    input  logic              batch_end,
    input  logic [POS_W-1:0]  max_length,
    output logic              busy,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [POS_W-1:0]  line_length,
    output logic [POS_W-1:0]  cursor_after,
    output logic [CHAR_W-1:0] read_char,
    output logic [CNT_W-1:0]  inserted_total,
    output logic [CNT_W-1:0]  deleted_total,
    output logic [CNT_W-1:0]  rejected_total,
    output logic              batch_done,
    output logic              ram_we,
    output logic [POS_W-1:0]  ram_waddr,
    output logic [CHAR_W-1:0] ram_wdata,
    output logic [POS_W-1:0]  ram_raddr,
    input  logic [CHAR_W-1:0] ram_rdata
);

    localparam int CAP_M1 = BUF_CAP - 1;

    state_t state_reg, state_next;

    op_t               op_reg, op_next, op_dec;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              bend_reg, bend_next;
    logic [POS_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  wr_addr_reg, wr_addr_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  cur_reg, cur_next;
    logic              open_reg, open_next;
    logic [CNT_W-1:0]  ins_cnt_reg, ins_cnt_next;
    logic [CNT_W-1:0]  del_cnt_reg, del_cnt_next;
    logic [CNT_W-1:0]  rej_cnt_reg, rej_cnt_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [CHAR_W-1:0] rd_char_reg, rd_char_next;
    logic              done_reg, done_next;

    logic [CHAR_W-1:0] key_char;
    logic              printable;
    logic [POS_W-1:0]  eff_max;
    logic              is_shift_op;
    logic              shift_down;
    logic [POS_W-1:0]  step_fwd;
    logic [POS_W-1:0]  step_dst;

    assign key_char  = key_code[CHAR_W-1:0];
    assign printable = (key_code[KEY_W-1:CHAR_W] == '0) &&
                       (key_char >= PRINT_LO) && (key_char <= PRINT_HI);

    always_comb
    begin
        if (32'(max_length) < CAP_M1)
        begin
            eff_max = max_length;
        end
        else
        begin
            eff_max = POS_W'(CAP_M1);
        end
    end

    always_comb
    begin
        op_dec = OP_NOP;
        case (func)
            FN_KEY:
            begin
                if (!open_reg)
                begin
                    op_dec = OP_IGN;
                end
                else if (key_char == KEY_CR || key_char == KEY_LF)
                begin
                    op_dec = OP_ACC;
                end
                else if (key_char == KEY_ESC)
                begin
                    op_dec = OP_CAN;
                end
                else if (key_char == KEY_BS)
                begin
                    op_dec = (cur_reg == '0) ? OP_REJ : OP_BKSP;
                end
                else if (key_char == KEY_DEL)
                begin
                    op_dec = (cur_reg >= len_reg) ? OP_REJ : OP_DELETE;
                end
                else if (printable && (len_reg < eff_max))
                begin
                    op_dec = OP_INS;
                end
                else
                begin
                    op_dec = OP_REJ;
                end
            end
            FN_CLEAR:  op_dec = OP_CLEAR;
            FN_APPEND: op_dec = OP_APPEND;
            FN_SETCUR: op_dec = OP_SETCUR;
            FN_READ:   op_dec = OP_READ;
            default:   op_dec = OP_NOP;
        endcase
    end

    assign is_shift_op = (op_dec == OP_INS) || (op_dec == OP_BKSP) || (op_dec == OP_DELETE);

    // Insertion moves entries toward the end, reading downward from the tail;
    // deletion moves them toward the front, reading upward.
    assign shift_down = (op_reg == OP_INS);
    assign step_fwd   = shift_down ? rd_ptr_reg - 1'b1 : rd_ptr_reg + 1'b1;
    assign step_dst   = shift_down ? rd_ptr_reg + 1'b1 : rd_ptr_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = is_shift_op ? S_SHIFT : S_FIN;
                end
            end
            S_SHIFT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        ram_raddr = rd_ptr_reg;
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = position;
            end
            S_SHIFT:
            begin
                ram_we = wr_pend_reg;
            end
            S_FIN:
            begin
                if (op_reg == OP_INS)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = char_reg;
                end
                else if (op_reg == OP_APPEND && len_reg < eff_max)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = len_reg;
                    ram_wdata = char_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        char_next    = char_reg;
        pos_next     = pos_reg;
        bend_next    = bend_reg;
        rd_ptr_next  = rd_ptr_reg;
        cnt_next     = cnt_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = 1'b0;
        len_next     = len_reg;
        cur_next     = cur_reg;
        open_next    = open_reg;
        ins_cnt_next = ins_cnt_reg;
        del_cnt_next = del_cnt_reg;
        rej_cnt_next = rej_cnt_reg;
        status_next  = status_reg;
        rd_char_next = rd_char_reg;
        done_next    = (state_reg == S_FIN);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = op_dec;
                    char_next = key_char;
                    pos_next  = position;
                    bend_next = batch_end;
                    case (op_dec)
                        OP_BKSP:
                        begin
                            rd_ptr_next = cur_reg;
                            cnt_next    = len_reg - cur_reg;
                        end
                        OP_DELETE:
                        begin
                            rd_ptr_next = cur_reg + 1'b1;
                            cnt_next    = len_reg - cur_reg - 1'b1;
                        end
                        OP_INS:
                        begin
                            rd_ptr_next = len_reg - 1'b1;
                            cnt_next    = len_reg - cur_reg;
                        end
                        default:
                        begin
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (cnt_reg != '0)
                begin
                    rd_ptr_next  = step_fwd;
                    cnt_next     = cnt_reg - 1'b1;
                    wr_addr_next = step_dst;
                    wr_pend_next = 1'b1;
                end
            end
            S_FIN:
            begin
                rd_char_next = '0;
                status_next  = ST_DONE;
                case (op_reg)
                    OP_IGN:
                    begin
                        status_next = ST_IGN;
                    end
                    OP_ACC:
                    begin
                        open_next   = 1'b0;
                        status_next = ST_ACC;
                    end
                    OP_CAN:
                    begin
                        open_next   = 1'b0;
                        status_next = ST_CAN;
                    end
                    OP_REJ:
                    begin
                        rej_cnt_next = sat_inc(rej_cnt_reg);
                        status_next  = ST_REJ;
                    end
                    OP_BKSP:
                    begin
                        len_next     = len_reg - 1'b1;
                        cur_next     = cur_reg - 1'b1;
                        del_cnt_next = sat_inc(del_cnt_reg);
                        status_next  = ST_DEL;
                    end
                    OP_DELETE:
                    begin
                        len_next     = len_reg - 1'b1;
                        del_cnt_next = sat_inc(del_cnt_reg);
                        status_next  = ST_DEL;
                    end
                    OP_INS:
                    begin
                        len_next     = len_reg + 1'b1;
                        cur_next     = cur_reg + 1'b1;
                        ins_cnt_next = sat_inc(ins_cnt_reg);
                        status_next  = ST_INS;
                    end
                    OP_CLEAR:
                    begin
                        len_next     = '0;
                        cur_next     = '0;
                        open_next    = 1'b1;
                        ins_cnt_next = '0;
                        del_cnt_next = '0;
                        rej_cnt_next = '0;
                    end
                    OP_APPEND:
                    begin
                        if (len_reg < eff_max)
                        begin
                            len_next = len_reg + 1'b1;
                        end
                    end
                    OP_SETCUR:
                    begin
                        cur_next = (pos_reg < len_reg) ? pos_reg : len_reg;
                    end
                    OP_READ:
                    begin
                        if (pos_reg < len_reg)
                        begin
                            rd_char_next = ram_rdata;
                        end
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
            end
            default:
            begin
                wr_pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wr_pend_reg <= 1'b0;
            len_reg     <= '0;
            cur_reg     <= '0;
            open_reg    <= 1'b1;
            ins_cnt_reg <= '0;
            del_cnt_reg <= '0;
            rej_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_pend_reg <= wr_pend_next;
            len_reg     <= len_next;
            cur_reg     <= cur_next;
            open_reg    <= open_next;
            ins_cnt_reg <= ins_cnt_next;
            del_cnt_reg <= del_cnt_next;
            rej_cnt_reg <= rej_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        char_reg    <= char_next;
        pos_reg     <= pos_next;
        bend_reg    <= bend_next;
        rd_ptr_reg  <= rd_ptr_next;
        cnt_reg     <= cnt_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
        rd_char_reg <= rd_char_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign line_length    = len_reg;
    assign cursor_after   = cur_reg;
    assign read_char      = rd_char_reg;
    assign inserted_total = ins_cnt_reg;
    assign deleted_total  = del_cnt_reg;
    assign rejected_total = rej_cnt_reg;
    assign batch_done     = bend_reg;

endmodule

// ===== rtl/cursor_line_editor.sv =====
// Cursor line editor top level: configuration port, character RAM and core.
// A word that moves stored characters steps through S_SHIFT and then S_FIN before done strobes;
// every other word goes from S_IDLE straight to S_FIN. A new word is taken only in S_IDLE,
// once busy falls; the single RAM read and write port moves one character per cycle.
// Reset clears the line, the cursor and the counters, opens the session and sets
// max_length to 31; results cannot be stalled and are valid only while done is high.
module cursor_line_editor
    import cle_pkg::*;
#(
    parameter int BUF_CAP = BUF_CAP_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [KEY_W-1:0]  key_code,
    input  logic [POS_W-1:0]  position,
    input  logic              batch_end,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [POS_W-1:0]  line_length,
    output logic [POS_W-1:0]  cursor_after,
    output logic [CHAR_W-1:0] read_char,
    output logic [CNT_W-1:0]  inserted_total,
    output logic [CNT_W-1:0]  deleted_total,
    output logic [CNT_W-1:0]  rejected_total,
    output logic              batch_done
);

    localparam int RAM_DEPTH = BUF_CAP - 1;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    logic [POS_W-1:0]  max_length_reg, max_length_next;
    logic              cfg_write;

    logic              ram_we;
    logic [POS_W-1:0]  ram_waddr;
    logic [POS_W-1:0]  ram_raddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [CHAR_W-1:0] ram_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LENGTH);

    always_comb
    begin
        max_length_next = max_length_reg;
        if (cfg_write)
        begin
            max_length_next = pwdata[POS_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_LENGTH)
        begin
            prdata = {{(32 - POS_W){1'b0}}, max_length_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

    cle_core #(
        .BUF_CAP (BUF_CAP)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .func           (func),
        .key_code       (key_code),
        .position       (position),
        .batch_end      (batch_end),
        .max_length     (max_length_reg),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .line_length    (line_length),
        .cursor_after   (cursor_after),
        .read_char      (read_char),
        .inserted_total (inserted_total),
        .deleted_total  (deleted_total),
        .rejected_total (rejected_total),
        .batch_done     (batch_done),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    cle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (RAM_DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (RAM_AW'(ram_waddr)),
        .wdata (ram_wdata),
        .raddr (RAM_AW'(ram_raddr)),
        .rdata (ram_rdata)
    );

endmodule
